// File: rtl/core/dxn_pkg.sv
`timescale 1ns / 1ps

package dxn_pkg;

  // field widths
  localparam int VALUE_W    = 64;
  localparam int COUNT_W    = 32;
  localparam int NIB_W      = 4;
  localparam int BYTE_W     = 8;
  localparam int LEAD_W     = 4;
  localparam int BYTE_IDX_W = 4;

  // count nibble, then up to sixteen data nibbles, plus one held nibble
  localparam int PACK_W = VALUE_W + 2 * NIB_W;

  // context hash takes the delta from this bit up
  localparam int HASH_SHIFT = 40;

  // generation tag kept beside each table entry
  localparam int EPOCH_W = 8;

  localparam int TABLE_ENTRIES_DEFAULT = 1024;

  typedef struct packed {
    logic [VALUE_W-1:0] value_bits;
    logic               chunk_last;
  } in_word_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  out_byte;
    logic               run_last;
    logic [COUNT_W-1:0] nibble_total;
  } out_word_t;

  // prediction residue handed from the predictor to the packer
  typedef struct packed {
    logic [VALUE_W-1:0] diff;
    logic               last;
  } diff_word_t;

endpackage

// File: rtl/core/dxn_ram.sv
`timescale 1ns / 1ps

module dxn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read-first: a read at the written address returns the old entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/dxn_predictor.sv
`timescale 1ns / 1ps

module dxn_predictor #(
  parameter int TABLE_ENTRIES = dxn_pkg::TABLE_ENTRIES_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                sample_valid,
  output logic                sample_stall,
  input  dxn_pkg::in_word_t   sample,
  output logic                diff_valid,
  input  logic                diff_stall,
  output dxn_pkg::diff_word_t diff
);

  localparam int IW      = $clog2(TABLE_ENTRIES);
  localparam int ENTRY_W = dxn_pkg::VALUE_W + dxn_pkg::EPOCH_W;
  localparam logic [IW-1:0] IDX_MASK  = IW'(TABLE_ENTRIES - 1);
  localparam logic [IW-1:0] LAST_ADDR = IW'(TABLE_ENTRIES - 1);
  localparam logic [dxn_pkg::EPOCH_W-1:0] EPOCH_MAX = '1;

  logic [IW-1:0]               context_hash;
  logic [IW-1:0]               hash_next;
  logic [dxn_pkg::VALUE_W-1:0] previous_value;
  logic [dxn_pkg::EPOCH_W-1:0] epoch;
  logic                        clearing;
  logic [IW-1:0]               clr_addr;

  logic                        accept;
  logic [dxn_pkg::VALUE_W-1:0] delta;

  logic                        ram_we;
  logic [IW-1:0]               ram_waddr;
  logic [ENTRY_W-1:0]          ram_wdata;
  logic [ENTRY_W-1:0]          ram_rdata;

  // read stage
  logic                        b_valid;
  logic [dxn_pkg::VALUE_W-1:0] b_value;
  logic [dxn_pkg::VALUE_W-1:0] b_prev;
  logic                        b_last;
  logic [dxn_pkg::EPOCH_W-1:0] b_epoch;
  logic [dxn_pkg::VALUE_W-1:0] entry_delta;
  logic [dxn_pkg::VALUE_W-1:0] predicted;

  logic c_free;
  logic b_adv;
  logic b_free;

  assign c_free       = !diff_valid || !diff_stall;
  assign b_adv        = b_valid && c_free;
  assign b_free       = !b_valid || b_adv;
  assign sample_stall = clearing || !b_free;
  assign accept       = sample_valid && !sample_stall;

  assign delta     = sample.value_bits - previous_value;
  assign hash_next = (IW'({context_hash, 2'b00}) ^ delta[dxn_pkg::HASH_SHIFT +: IW]) & IDX_MASK;

  assign ram_we    = accept || clearing;
  assign ram_waddr = clearing ? clr_addr : context_hash;
  assign ram_wdata = clearing ? '0 : {epoch, delta};

  dxn_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_ENTRIES)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (accept),
    .raddr(context_hash),
    .rdata(ram_rdata)
  );

  // an entry from an older chunk reads as zero
  assign entry_delta = (ram_rdata[ENTRY_W-1 -: dxn_pkg::EPOCH_W] == b_epoch)
                     ? ram_rdata[dxn_pkg::VALUE_W-1:0] : '0;
  assign predicted   = entry_delta + b_prev;

  always_ff @(posedge clk) begin
    if (rst) begin
      context_hash   <= '0;
      previous_value <= '0;
      epoch          <= '0;
      clearing       <= 1'b1;
      clr_addr       <= '0;
      b_valid        <= 1'b0;
      diff_valid     <= 1'b0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + IW'(1);
        if (clr_addr == LAST_ADDR) begin
          clearing <= 1'b0;
        end
      end
      if (accept) begin
        if (sample.chunk_last) begin
          context_hash   <= '0;
          previous_value <= '0;
          epoch          <= epoch + dxn_pkg::EPOCH_W'(1);
          if (epoch == EPOCH_MAX) begin
            clearing <= 1'b1;
            clr_addr <= '0;
          end
        end else begin
          context_hash   <= hash_next;
          previous_value <= sample.value_bits;
        end
      end
      if (b_free) begin
        b_valid <= accept;
      end
      if (c_free) begin
        diff_valid <= b_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_value <= sample.value_bits;
      b_prev  <= previous_value;
      b_last  <= sample.chunk_last;
      b_epoch <= epoch;
    end
    if (b_adv) begin
      diff.diff <= b_value ^ predicted;
      diff.last <= b_last;
    end
  end

endmodule

// File: rtl/core/dxn_packer.sv
`timescale 1ns / 1ps

module dxn_packer (
  input  logic                clk,
  input  logic                rst,
  input  logic                diff_valid,
  output logic                diff_stall,
  input  dxn_pkg::diff_word_t diff,
  output logic                code_valid,
  input  logic                code_stall,
  output dxn_pkg::out_word_t  code
);

  // index of the highest nonzero nibble, zero for an all-zero word
  function automatic logic [dxn_pkg::LEAD_W-1:0] top_nibble(
    input logic [dxn_pkg::VALUE_W-1:0] x
  );
    logic [dxn_pkg::LEAD_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < dxn_pkg::VALUE_W / dxn_pkg::NIB_W; i++) begin
      if (x[i*dxn_pkg::NIB_W +: dxn_pkg::NIB_W] != '0) begin
        idx = dxn_pkg::LEAD_W'(i);
      end
    end
    return idx;
  endfunction

  logic [dxn_pkg::COUNT_W-1:0]    nibble_count;
  logic [dxn_pkg::NIB_W-1:0]      held_nibble;

  logic                           busy;
  logic [dxn_pkg::PACK_W-1:0]     s_vec;
  logic [dxn_pkg::BYTE_IDX_W-1:0] s_idx;
  logic [dxn_pkg::BYTE_IDX_W-1:0] s_nb;
  logic                           s_last;
  logic [dxn_pkg::COUNT_W-1:0]    s_total;

  logic                           final_byte;
  logic                           emit;
  logic                           load;

  logic                           held_flag;
  logic [dxn_pkg::LEAD_W-1:0]     lead;
  logic [4:0]                     run_len;
  logic [4:0]                     stream_len;
  logic [dxn_pkg::PACK_W-1:0]     vec;
  logic [dxn_pkg::BYTE_IDX_W-1:0] nb;
  logic [dxn_pkg::COUNT_W-1:0]    count_sum;
  logic [dxn_pkg::NIB_W-1:0]      held_next;

  assign final_byte = (s_idx == s_nb - dxn_pkg::BYTE_IDX_W'(1));
  assign emit       = busy && (!code_valid || !code_stall);
  assign diff_stall = busy && !(emit && final_byte);
  assign load       = diff_valid && !diff_stall;

  assign held_flag  = nibble_count[0];
  assign lead       = top_nibble(diff.diff);
  assign run_len    = 5'(lead) + 5'd2;
  assign stream_len = run_len + 5'(held_flag);
  assign vec        = held_flag ? {diff.diff, lead, held_nibble}
                                : {{dxn_pkg::NIB_W{1'b0}}, diff.diff, lead};
  assign nb         = stream_len[4:1] + dxn_pkg::BYTE_IDX_W'(diff.last & stream_len[0]);
  assign count_sum  = nibble_count + dxn_pkg::COUNT_W'(run_len);
  assign held_next  = stream_len[0] ? vec[{stream_len - 5'd1, 2'b00} +: dxn_pkg::NIB_W] : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      code_valid   <= 1'b0;
      nibble_count <= '0;
      held_nibble  <= '0;
    end else begin
      if (emit) begin
        code_valid <= 1'b1;
      end else if (!code_stall) begin
        code_valid <= 1'b0;
      end
      if (load) begin
        busy <= 1'b1;
      end else if (emit && final_byte) begin
        busy <= 1'b0;
      end
      if (load) begin
        if (diff.last) begin
          nibble_count <= '0;
          held_nibble  <= '0;
        end else begin
          nibble_count <= count_sum;
          held_nibble  <= held_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      code.out_byte     <= s_vec[{s_idx, 3'b000} +: dxn_pkg::BYTE_W];
      code.run_last     <= final_byte;
      code.nibble_total <= (final_byte && s_last) ? s_total : '0;
    end
    if (load) begin
      s_vec   <= vec;
      s_idx   <= '0;
      s_nb    <= nb;
      s_last  <= diff.last;
      s_total <= count_sum;
    end else if (emit) begin
      s_idx   <= s_idx + dxn_pkg::BYTE_IDX_W'(1);
    end
  end

endmodule

// File: rtl/core/dfcm_xor_nibble_encoder.sv
// path: a sample passes the predictor read stage, residue register, packer byte registers
//   and code output register. throughput: one byte per cycle while code_stall is low;
//   a sample makes 1 to 9 bytes, so the byte port sets the sustained sample rate
// reset: synchronous; after reset, and after every 256th chunk end, a clearing pass over all
//   TABLE_ENTRIES entries sweeps the delta table while samples are stalled
`timescale 1ns / 1ps

module dfcm_xor_nibble_encoder #(
  parameter int TABLE_ENTRIES = dxn_pkg::TABLE_ENTRIES_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  // sample words in
  input  logic               sample_valid,
  output logic               sample_stall,
  input  dxn_pkg::in_word_t  sample,
  // packed code bytes out
  output logic               code_valid,
  input  logic               code_stall,
  output dxn_pkg::out_word_t code
);

  // residue words between predictor and packer
  logic                diff_valid;
  logic                diff_stall;
  dxn_pkg::diff_word_t diff;

  // predictor: table lookup, delta write-back and hash update happen in the
  // cycle a sample is taken; the table sits in one read-first ram, so a
  // sample that reads the entry its predecessor just wrote sees the new delta
  // without forwarding. entries carry a chunk tag, and a tag from an older
  // chunk reads as zero, which stands in for clearing the table at chunk end
  dxn_predictor #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_predictor (
    .clk         (clk),
    .rst         (rst),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .sample      (sample),
    .diff_valid  (diff_valid),
    .diff_stall  (diff_stall),
    .diff        (diff)
  );

  // packer: count nibble plus residue nibbles, low nibble first, one byte
  // per cycle into the output register while code_stall is low; keeps the odd
  // nibble and the chunk nibble count across samples, flushes on chunk end
  dxn_packer u_packer (
    .clk       (clk),
    .rst       (rst),
    .diff_valid(diff_valid),
    .diff_stall(diff_stall),
    .diff      (diff),
    .code_valid(code_valid),
    .code_stall(code_stall),
    .code      (code)
  );

endmodule

// File: sim/dfcm_xor_nibble_encoder_tb.sv
`timescale 1ns / 1ps

module dfcm_xor_nibble_encoder_tb;
  import dxn_pkg::*;

  localparam int TBL_N = TABLE_ENTRIES_DEFAULT;
  localparam int HASH_W = $clog2(TBL_N);
  localparam logic [VALUE_W-1:0] HASH_MASK = VALUE_W'(TBL_N - 1);
  localparam int NIB_MAX = 15;
  // the clearing sweep after reset alone is a quiet stretch this limit must outlast
  localparam int IDLE_LIMIT = 5000;
  localparam int TAIL_CYCLES = 20;
  localparam int LONG_HOLD = 120;
  localparam int MAX_REPORTS = 10;

  // shapes of the sample runs fed to the predictor
  typedef enum int {SEQ_FLAT, SEQ_RAMP, SEQ_JITTER, SEQ_CYCLE, SEQ_NOISE} seq_kind_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      sample_valid;
  logic      sample_stall;
  in_word_t  sample;
  logic      code_valid;
  logic      code_stall;
  out_word_t code;

  dfcm_xor_nibble_encoder #(.TABLE_ENTRIES(TBL_N)) DUT (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .code_valid   (code_valid),
    .code_stall   (code_stall),
    .code         (code)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state, mirrors the encoder's context and packing registers
  logic [VALUE_W-1:0] delta_mem [TBL_N];
  logic [HASH_W-1:0]  hash_reg;
  logic [VALUE_W-1:0] prev_val;
  logic [NIB_W-1:0]   held;
  logic [COUNT_W-1:0] nib_cnt;

  // code bytes the predictor has produced and the encoder still owes
  out_word_t pending_code [$];

  int  mismatches = 0;
  int  samples_sent = 0;
  int  chunks_closed = 0;
  int  bytes_checked = 0;
  bit  send_gaps = 1'b0;
  bit  recv_gaps = 1'b0;
  int  hold_left = 0;
  int  stall_burst = 0;

  // start of a chunk: table, hash, previous value and nibble packer all clear
  task automatic clear_model();
    int i;
    for (i = 0; i < TBL_N; i++) delta_mem[i] = '0;
    hash_reg = '0;
    prev_val = '0;
    held     = '0;
    nib_cnt  = '0;
  endtask

  // turns one sample into the code bytes it should produce
  task automatic encode_sample(input logic [VALUE_W-1:0] v, input logic last);
    logic [VALUE_W-1:0] idx;
    logic [VALUE_W-1:0] guess;
    logic [VALUE_W-1:0] delta;
    logic [VALUE_W-1:0] resid;
    logic [NIB_W-1:0]   nib;
    int                 lz;
    int                 cnt;
    int                 i;
    int                 n;
    out_word_t          row [9];
    // prediction is the stored delta for this context plus the last value
    idx   = VALUE_W'(hash_reg) & HASH_MASK;
    guess = delta_mem[idx] + prev_val;
    delta = v - prev_val;
    delta_mem[idx] = delta;
    hash_reg = HASH_W'(((idx << 2) ^ (delta >> HASH_SHIFT)) & HASH_MASK);
    prev_val = v;
    resid = v ^ guess;
    // leading zeros; a zero residue counts as all 64
    lz = VALUE_W;
    for (i = 0; i < VALUE_W; i++) if (resid[i]) lz = VALUE_W - 1 - i;
    cnt = NIB_MAX - lz / 4;
    if (cnt < 0) cnt = 0;
    // count nibble first, then cnt+1 residue nibbles, low nibble first in each byte
    n = 0;
    for (i = 0; i < cnt + 2; i++) begin
      nib = (i == 0) ? NIB_W'(cnt) : resid[NIB_W*(i-1) +: NIB_W];
      if (!nib_cnt[0]) begin
        held = nib;
      end else begin
        row[n] = '{out_byte: {nib, held}, run_last: 1'b0, nibble_total: '0};
        n++;
        held = '0;
      end
      nib_cnt++;
    end
    // odd nibble at chunk end goes out alone with a zero high half
    if (last && nib_cnt[0]) begin
      row[n] = '{out_byte: {4'h0, held}, run_last: 1'b0, nibble_total: '0};
      n++;
    end
    row[n-1].run_last = 1'b1;
    if (last) row[n-1].nibble_total = nib_cnt;
    for (i = 0; i < n; i++) pending_code.insert(pending_code.size(), row[i]);
    if (last) clear_model();
  endtask

  // one sample word on the input channel, with an optional idle burst ahead of it
  task automatic offer_sample(input logic [VALUE_W-1:0] v, input logic last);
    int gap;
    if (send_gaps && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 14);
      repeat (gap) begin
        @(negedge clk);
        sample_valid <= 1'b0;
      end
    end
    @(negedge clk);
    sample_valid <= 1'b1;
    sample       <= '{value_bits: v, chunk_last: last};
    do @(posedge clk); while (sample_stall);
    encode_sample(v, last);
    samples_sent++;
    if (last) chunks_closed++;
  endtask

  // extremes, zero residues, special doubles, odd and even chunk ends
  task automatic test_directed();
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
    // two nibbles only: even chunk end, no flush byte
    offer_sample(64'h0000_0000_0000_0000, 1'b1);
    // seventeen nibbles: odd chunk end, held nibble flushed
    offer_sample(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    offer_sample(64'h0000_0000_0000_0000, 1'b0);
    offer_sample(64'h0000_0000_0000_0000, 1'b0);
    offer_sample(64'h8000_0000_0000_0000, 1'b0);
    offer_sample(64'h0000_0000_0000_0001, 1'b0);
    // repeated value, so the predictor hits and the residue is zero
    offer_sample(64'h3FF0_0000_0000_0000, 1'b0);
    offer_sample(64'h3FF0_0000_0000_0000, 1'b0);
    offer_sample(64'h3FF0_0000_0000_0000, 1'b0);
    offer_sample(64'h4000_0000_0000_0000, 1'b0);
    offer_sample(64'h4008_0000_0000_0000, 1'b0);
    offer_sample(64'h4010_0000_0000_0000, 1'b0);
    // infinity, nan, smallest normal, largest finite
    offer_sample(64'h7FF0_0000_0000_0000, 1'b0);
    offer_sample(64'hFFF8_0000_0000_0000, 1'b0);
    offer_sample(64'h0010_0000_0000_0000, 1'b0);
    offer_sample(64'h7FEF_FFFF_FFFF_FFFF, 1'b0);
    offer_sample(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
  endtask

  // chunks of shaped sample runs with random content, some cut short
  task automatic test_random_chunks(input int n_items);
    int                 left;
    int                 len;
    int                 k;
    seq_kind_t          kind;
    logic [VALUE_W-1:0] base;
    logic [VALUE_W-1:0] step;
    logic [VALUE_W-1:0] v;
    logic [VALUE_W-1:0] cyc [3];
    logic               last;
    left = n_items;
    while (left > 0) begin
      len = $urandom_range(1, 8);
      if (len > left) len = left;
      kind = seq_kind_t'($urandom_range(0, 4));
      // half the runs look like doubles of similar magnitude
      if ($urandom_range(0, 1) == 1)
        base = {1'($urandom_range(0, 1)), 11'($urandom_range(1000, 1050)),
                20'($urandom), 32'($urandom)};
      else
        base = {32'($urandom), 32'($urandom)};
      step = VALUE_W'($urandom) >> $urandom_range(0, 31);
      for (k = 0; k < 3; k++) cyc[k] = {32'($urandom), 32'($urandom)};
      for (k = 0; k < len; k++) begin
        case (kind)
          SEQ_FLAT:   v = base;
          SEQ_RAMP:   v = base + step * VALUE_W'(k);
          SEQ_JITTER: v = base ^ VALUE_W'($urandom_range(0, 255));
          SEQ_CYCLE:  v = cyc[k % 3];
          default:    v = {32'($urandom), 32'($urandom)};
        endcase
        // now and then a chunk ends early
        last = (k == len - 1) || ($urandom_range(0, 19) == 0);
        offer_sample(v, last);
      end
      left -= len;
    end
  endtask

  // output held off for a long stretch while samples keep coming
  task automatic test_backpressure();
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    @(posedge clk);
    hold_left = LONG_HOLD;
    test_random_chunks(24);
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
  endtask

  // input goes quiet until every owed byte is out, then resumes mid chunk
  task automatic test_drain_pause();
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
    offer_sample(64'h4059_0000_0000_0000, 1'b0);
    offer_sample(64'h4059_4000_0000_0000, 1'b0);
    offer_sample({32'($urandom), 32'($urandom)}, 1'b0);
    @(negedge clk);
    sample_valid <= 1'b0;
    wait (pending_code.size() == 0);
    offer_sample(64'h4059_8000_0000_0000, 1'b0);
    offer_sample(64'h4059_C000_0000_0000, 1'b0);
    offer_sample({32'($urandom), 32'($urandom)}, 1'b1);
  endtask

  // closing stretch with both sides running flat out
  task automatic test_steady_flow();
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    test_random_chunks(30);
  endtask

  // receiver: long hold first, otherwise random stall bursts
  initial begin
    code_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        code_stall <= 1'b1;
      end else if (stall_burst > 0) begin
        stall_burst--;
        code_stall <= 1'b1;
      end else if (recv_gaps && $urandom_range(0, 7) == 0) begin
        stall_burst = $urandom_range(1, 14) - 1;
        code_stall <= 1'b1;
      end else begin
        code_stall <= 1'b0;
      end
    end
  end

  // every accepted code byte against the oldest owed one
  always @(posedge clk) begin
    if (!rst && code_valid && !code_stall) begin
      if (pending_code.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected code byte: byte %02h last %0b total %0d",
                   code.out_byte, code.run_last, code.nibble_total);
      end else begin
        out_word_t want;
        want = pending_code.pop_front();
        bytes_checked++;
        if (code.out_byte !== want.out_byte || code.run_last !== want.run_last ||
            code.nibble_total !== want.nibble_total) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("code byte %0d: expected byte %02h last %0b total %0d, got %02h %0b %0d",
                     bytes_checked, want.out_byte, want.run_last, want.nibble_total,
                     code.out_byte, code.run_last, code.nibble_total);
        end
      end
    end
  end

  // watchdog on cycles where neither channel moves a word
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((sample_valid && !sample_stall) || (code_valid && !code_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
    $display("tb: failure");
    $finish;
  end

  initial begin
    sample_valid = 1'b0;
    sample       = '0;
    clear_model();
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_chunks(90);
    test_backpressure();
    test_drain_pause();
    test_steady_flow();
    @(negedge clk);
    sample_valid <= 1'b0;
    wait (pending_code.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("ran %0d samples in %0d closed chunks, %0d code bytes checked, %0d mismatches",
             samples_sent, chunks_closed, bytes_checked, mismatches);
    $display("zero and full-width residues, odd and even flushes, long hold and drain pause");
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
